/* sv/cc20_pkg.sv */
// Package for the ChaCha20 stream cipher: transaction types, cipher constants
// and the quarter-round / double-round functions. No dependencies.
`default_nettype none

package cc20_pkg;

  localparam logic [31:0] CC_SIGMA0 = 32'h61707865;
  localparam logic [31:0] CC_SIGMA1 = 32'h3320646e;
  localparam logic [31:0] CC_SIGMA2 = 32'h79622d32;
  localparam logic [31:0] CC_SIGMA3 = 32'h6b206574;

  localparam int CC_DROUNDS = 10;
  localparam int CC_RND_W   = 4;
  localparam int CC_WORDS   = 8;
  localparam int CC_WPOS_W  = 3;

  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;

  localparam logic [2:0] CFG_KEY01   = 3'd0;
  localparam logic [2:0] CFG_KEY23   = 3'd1;
  localparam logic [2:0] CFG_KEY45   = 3'd2;
  localparam logic [2:0] CFG_KEY67   = 3'd3;
  localparam logic [2:0] CFG_NONCE01 = 3'd4;
  localparam logic [2:0] CFG_NONCE2  = 3'd5;

  typedef struct packed {
    logic [63:0] data_in;
    logic [3:0]  valid_bytes;
    logic        start_of_message;
  } in_item_t;

  typedef struct packed {
    logic [63:0] data_out;
    logic [3:0]  valid_bytes_out;
  } out_item_t;

  // Classified entry handed from the front end to the back end
  typedef struct packed {
    logic [63:0] data;
    logic [7:0]  byte_mask;
    logic [3:0]  valid_bytes;
    logic        sop;
  } q_item_t;

  typedef struct packed {
    logic [7:0][31:0] key;
    logic [2:0][31:0] nonce;
  } cc_cfg_t;

  typedef logic [15:0][31:0] cc_state_t;
  typedef logic [7:0][63:0]  cc_block_t;

  typedef enum logic {
    BK_RUN,
    BK_GEN
  } bk_state_t;

  function automatic logic [3:0][31:0] cc_qr(input logic [31:0] a_i, input logic [31:0] b_i,
                                             input logic [31:0] c_i, input logic [31:0] d_i);
    logic [31:0] a, b, c, d;
    logic [3:0][31:0] r;
    a = a_i; b = b_i; c = c_i; d = d_i;
    a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
    c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
    a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
    c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
    r[0] = a; r[1] = b; r[2] = c; r[3] = d;
    return r;
  endfunction

  function automatic cc_state_t cc_dround(input cc_state_t s);
    cc_state_t t;
    logic [3:0][31:0] q;
    t = s;
    // column round
    q = cc_qr(t[0], t[4], t[8],  t[12]); t[0] = q[0]; t[4] = q[1]; t[8]  = q[2]; t[12] = q[3];
    q = cc_qr(t[1], t[5], t[9],  t[13]); t[1] = q[0]; t[5] = q[1]; t[9]  = q[2]; t[13] = q[3];
    q = cc_qr(t[2], t[6], t[10], t[14]); t[2] = q[0]; t[6] = q[1]; t[10] = q[2]; t[14] = q[3];
    q = cc_qr(t[3], t[7], t[11], t[15]); t[3] = q[0]; t[7] = q[1]; t[11] = q[2]; t[15] = q[3];
    // diagonal round
    q = cc_qr(t[0], t[5], t[10], t[15]); t[0] = q[0]; t[5] = q[1]; t[10] = q[2]; t[15] = q[3];
    q = cc_qr(t[1], t[6], t[11], t[12]); t[1] = q[0]; t[6] = q[1]; t[11] = q[2]; t[12] = q[3];
    q = cc_qr(t[2], t[7], t[8],  t[13]); t[2] = q[0]; t[7] = q[1]; t[8]  = q[2]; t[13] = q[3];
    q = cc_qr(t[3], t[4], t[9],  t[14]); t[3] = q[0]; t[4] = q[1]; t[9]  = q[2]; t[14] = q[3];
    return t;
  endfunction

endpackage

`default_nettype wire

/* sv/cc20_front.sv */
// Front end: accepts input transactions, derives the byte mask and queues them.
// Depends on cc20_pkg.
`default_nettype none

module cc20_front
  import cc20_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          q_valid,
  input  wire logic     q_stall,
  output q_item_t       q_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_item_t           entries_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push, pop;
  q_item_t           entry_in;

  always_comb begin
    entry_in.data        = in_data.data_in;
    entry_in.valid_bytes = in_data.valid_bytes;
    entry_in.sop         = in_data.start_of_message;
    for (int i = 0; i < 8; i++) begin
      entry_in.byte_mask[i] = (in_data.valid_bytes > 4'(i));
    end
  end

  assign in_stall = (count_r == CNT_W'(DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = entries_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_valid && !q_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= entry_in;
    end
  end

endmodule

`default_nettype wire

/* sv/cc20_core.sv */
// ChaCha20 block core: one double round per cycle, feed-forward add on output.
// Depends on cc20_pkg.
`default_nettype none

module cc20_core
  import cc20_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire cc_state_t init,
  output logic           done,
  output cc_block_t      ks
);

  cc_state_t           x_r, x_nxt;
  cc_state_t           init_r;
  logic [CC_RND_W-1:0] rnd_r, rnd_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;

  always_comb begin
    x_nxt    = x_r;
    rnd_nxt  = rnd_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = init;
      rnd_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_nxt   = cc_dround(x_r);
      rnd_nxt = rnd_r + 1'b1;
      if (rnd_r == CC_RND_W'(CC_DROUNDS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      rnd_r  <= rnd_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    if (start) begin
      init_r <= init;
    end
  end

  always_comb begin
    for (int i = 0; i < CC_WORDS; i++) begin
      ks[i] = {x_r[2*i+1] + init_r[2*i+1], x_r[2*i] + init_r[2*i]};
    end
  end

  assign done = done_r;

endmodule

`default_nettype wire

/* sv/cc20_back.sv */
// Back end: block counter, keystream store, block requests and the output register.
// Depends on cc20_pkg and cc20_core.
`default_nettype none

module cc20_back
  import cc20_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cc_cfg_t cfg,
  input  wire logic    q_valid,
  output logic         q_stall,
  input  wire q_item_t q_item,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_item_t    out_data
);

  bk_state_t            state_r, state_nxt;
  logic [31:0]          block_counter_r, block_counter_nxt;
  logic [CC_WPOS_W-1:0] wpos_r, wpos_nxt;
  logic                 ks_ready_r, ks_ready_nxt;
  logic                 sop_served_r, sop_served_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r;
  logic [63:0]          ks_r [CC_WORDS];

  logic        consume, gen_start, load_ok, need_blk, sop_pending;
  logic [31:0] gen_ctr;
  cc_state_t   core_init;
  logic        core_done;
  cc_block_t   core_ks;
  logic [63:0] mask64;

  cc20_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .start (gen_start),
    .init  (core_init),
    .done  (core_done),
    .ks    (core_ks)
  );

  assign load_ok     = !out_valid_r || !out_stall;
  assign sop_pending = q_item.sop && !sop_served_r;
  assign need_blk    = !ks_ready_r || sop_pending;
  assign core_init   = {cfg.nonce, gen_ctr, cfg.key, CC_SIGMA3, CC_SIGMA2, CC_SIGMA1, CC_SIGMA0};

  always_comb begin
    state_nxt         = state_r;
    block_counter_nxt = block_counter_r;
    wpos_nxt          = wpos_r;
    ks_ready_nxt      = ks_ready_r;
    sop_served_nxt    = sop_served_r;
    consume           = 1'b0;
    gen_start         = 1'b0;
    gen_ctr           = block_counter_r;
    unique case (state_r)
      BK_RUN: begin
        if (q_valid) begin
          if (need_blk) begin
            gen_start         = 1'b1;
            gen_ctr           = sop_pending ? 32'd0 : block_counter_r;
            block_counter_nxt = gen_ctr + 32'd1;
            sop_served_nxt    = q_item.sop;
            ks_ready_nxt      = 1'b0;
            state_nxt         = BK_GEN;
          end else if (load_ok) begin
            consume        = 1'b1;
            sop_served_nxt = 1'b0;
            wpos_nxt       = wpos_r + 1'b1;
            if (wpos_r == CC_WPOS_W'(CC_WORDS - 1)) begin
              ks_ready_nxt = 1'b0;
            end
          end
        end
      end
      BK_GEN: begin
        if (core_done) begin
          ks_ready_nxt = 1'b1;
          wpos_nxt     = '0;
          state_nxt    = BK_RUN;
        end
      end
      default: state_nxt = BK_RUN;
    endcase
  end

  assign q_stall = !consume;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      mask64[8*i +: 8] = {8{q_item.byte_mask[i]}};
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (consume) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= BK_RUN;
      block_counter_r <= '0;
      wpos_r          <= '0;
      ks_ready_r      <= 1'b0;
      sop_served_r    <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      block_counter_r <= block_counter_nxt;
      wpos_r          <= wpos_nxt;
      ks_ready_r      <= ks_ready_nxt;
      sop_served_r    <= sop_served_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (core_done) begin
      for (int i = 0; i < CC_WORDS; i++) begin
        ks_r[i] <= core_ks[i];
      end
    end
    if (consume) begin
      out_data_r.data_out        <= (q_item.data ^ ks_r[wpos_r]) & mask64;
      out_data_r.valid_bytes_out <= q_item.valid_bytes;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* sv/chacha20_stream_cipher.sv */
// ChaCha20 stream cipher (96-bit nonce), 64-bit words. An accepted word passes
// through the front-end queue and the output register; when no keystream block
// is on hand, the core first makes one (10 double rounds plus request and store).
// Each block serves 8 words; the back end takes no new word while a block is made.
// Synchronous active-low reset clears the queue, counter and key/nonce registers.
// Depends on cc20_pkg, cc20_front, cc20_back.
`default_nettype none

module chacha20_stream_cipher
  import cc20_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic [63:0] key01_r, key23_r, key45_r, key67_r, nonce01_r;
  logic [31:0] nonce2_r;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  cc_cfg_t     cfg;
  logic        q_valid, q_stall;
  q_item_t     q_item;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[5:3];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key01_r   <= '0;
      key23_r   <= '0;
      key45_r   <= '0;
      key67_r   <= '0;
      nonce01_r <= '0;
      nonce2_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        CFG_KEY01:   key01_r   <= cfg_pwdata;
        CFG_KEY23:   key23_r   <= cfg_pwdata;
        CFG_KEY45:   key45_r   <= cfg_pwdata;
        CFG_KEY67:   key67_r   <= cfg_pwdata;
        CFG_NONCE01: nonce01_r <= cfg_pwdata;
        CFG_NONCE2:  nonce2_r  <= cfg_pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_KEY01:   cfg_prdata = key01_r;
      CFG_KEY23:   cfg_prdata = key23_r;
      CFG_KEY45:   cfg_prdata = key45_r;
      CFG_KEY67:   cfg_prdata = key67_r;
      CFG_NONCE01: cfg_prdata = nonce01_r;
      CFG_NONCE2:  cfg_prdata = {32'd0, nonce2_r};
      default:     cfg_prdata = '0;
    endcase
  end

  assign cfg.key   = {key67_r, key45_r, key23_r, key01_r};
  assign cfg.nonce = {nonce2_r, nonce01_r};

  cc20_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_stall  (q_stall),
    .q_item   (q_item)
  );

  cc20_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_stall   (q_stall),
    .q_item    (q_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* tb/chacha20_stream_cipher_test.sv */
// Self-checking testbench for chacha20_stream_cipher: an internal ChaCha20 keystream model
// predicts every output word. The configuration port, both handshakes and random idling are driven.
// Depends on cc20_pkg and chacha20_stream_cipher.
`default_nettype none

module chacha20_stream_cipher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cc20_pkg::*;

  localparam int SETTLE_CYCLES = 24;
  localparam int WORD_TARGET   = 450;

  class keystream_scoreboard;
    bit [63:0]  key_nonce[6];
    bit [63:0]  ks_words[8];
    bit [31:0]  mix[16];
    bit [31:0]  blk_ctr;
    bit [2:0]   word_pos;
    bit         ks_ready;
    out_item_t  expected_words[$];
    int         errors;

    function new();
      foreach (key_nonce[i]) key_nonce[i] = '0;
      foreach (ks_words[i]) ks_words[i] = '0;
      blk_ctr  = '0;
      word_pos = '0;
      ks_ready = 1'b0;
      errors   = 0;
    endfunction

    function void set_reg(int idx, bit [63:0] value);
      key_nonce[idx] = (idx == int'(CFG_NONCE2)) ? {32'd0, value[31:0]} : value;
    endfunction

    function bit [31:0] rotl(bit [31:0] v, int n);
      return (v << n) | (v >> (32 - n));
    endfunction

    function void quarter(int a, int b, int c, int d);
      mix[a] += mix[b]; mix[d] ^= mix[a]; mix[d] = rotl(mix[d], 16);
      mix[c] += mix[d]; mix[b] ^= mix[c]; mix[b] = rotl(mix[b], 12);
      mix[a] += mix[b]; mix[d] ^= mix[a]; mix[d] = rotl(mix[d], 8);
      mix[c] += mix[d]; mix[b] ^= mix[c]; mix[b] = rotl(mix[b], 7);
    endfunction

    function void make_keystream_block();
      bit [31:0] init[16];
      init[0] = CC_SIGMA0;
      init[1] = CC_SIGMA1;
      init[2] = CC_SIGMA2;
      init[3] = CC_SIGMA3;
      for (int i = 0; i < 4; i++) begin
        init[4 + 2 * i] = key_nonce[i][31:0];
        init[5 + 2 * i] = key_nonce[i][63:32];
      end
      init[12] = blk_ctr;
      init[13] = key_nonce[CFG_NONCE01][31:0];
      init[14] = key_nonce[CFG_NONCE01][63:32];
      init[15] = key_nonce[CFG_NONCE2][31:0];
      mix = init;
      for (int r = 0; r < 10; r++) begin
        quarter(0, 4, 8, 12);
        quarter(1, 5, 9, 13);
        quarter(2, 6, 10, 14);
        quarter(3, 7, 11, 15);
        quarter(0, 5, 10, 15);
        quarter(1, 6, 11, 12);
        quarter(2, 7, 8, 13);
        quarter(3, 4, 9, 14);
      end
      for (int i = 0; i < 8; i++)
        ks_words[i] = {mix[2 * i + 1] + init[2 * i + 1], mix[2 * i] + init[2 * i]};
    endfunction

    // predicts the cipher word for an accepted input transaction
    function void note_input(in_item_t it);
      out_item_t  exp_word;
      bit [63:0]  ks;
      bit [63:0]  mask;
      int         n;
      if (it.start_of_message) begin
        blk_ctr  = '0;
        word_pos = '0;
        ks_ready = 1'b0;
      end
      if (!ks_ready) begin
        make_keystream_block();
        blk_ctr  = blk_ctr + 32'd1;
        word_pos = '0;
        ks_ready = 1'b1;
      end
      ks       = ks_words[word_pos];
      word_pos = word_pos + 3'd1;
      if (word_pos == 3'd0) ks_ready = 1'b0;
      n    = (it.valid_bytes > 4'd8) ? 8 : int'(it.valid_bytes);
      mask = (n == 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
      exp_word.data_out        = (it.data_in ^ ks) & mask;
      exp_word.valid_bytes_out = it.valid_bytes;
      expected_words.push_back(exp_word);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_word;
      if (expected_words.size() == 0) begin
        $error("unexpected result: data_out %h valid_bytes_out %0d",
               got.data_out, got.valid_bytes_out);
        errors++;
        return;
      end
      exp_word = expected_words.pop_front();
      if (got.data_out !== exp_word.data_out) begin
        $error("data_out: expected %h, got %h", exp_word.data_out, got.data_out);
        errors++;
      end
      if (got.valid_bytes_out !== exp_word.valid_bytes_out) begin
        $error("valid_bytes_out: expected %0d, got %0d",
               exp_word.valid_bytes_out, got.valid_bytes_out);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  keystream_scoreboard ks_board = new();
  bit                  idle_on = 1'b1;
  int                  words_sent = 0;

  chacha20_stream_cipher i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #2 clk = ~clk;

  // both channels sampled in one place so input and result order is fixed
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) ks_board.note_input(in_data);
      if (out_valid && !out_stall) ks_board.check_result(out_data);
    end
  end

  // receiver back-pressure: stretches of varying density, now and then a long hold
  initial begin
    int stretch;
    int density;
    forever begin
      stretch = $urandom_range(20, 120);
      case ($urandom_range(0, 3))
        0:       density = 0;
        1:       density = 15;
        2:       density = 40;
        default: density = 70;
      endcase
      repeat (stretch) begin
        @(posedge clk);
        out_stall <= ($urandom_range(0, 99) < density);
      end
      if ($urandom_range(0, 4) == 0) begin
        @(posedge clk);
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_word(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_fields(logic [63:0] data, logic [3:0] vb, logic sop);
    in_item_t it;
    it.data_in          = data;
    it.valid_bytes      = vb;
    it.start_of_message = sop;
    send_word(it);
  endtask

  // sender holds off until every expected word is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (ks_board.expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    ks_board.set_reg(int'(idx), value);
  endtask

  task automatic quiesce();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_reg_value(bit narrow);
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = '1;
      default: v = {$urandom, $urandom};
    endcase
    return narrow ? {32'd0, v[31:0]} : v;
  endfunction

  task automatic send_message(int len, bit with_sop, bit noisy);
    in_item_t it;
    for (int i = 0; i < len; i++) begin
      it.data_in          = {$urandom, $urandom};
      it.start_of_message = (i == 0) && with_sop;
      it.valid_bytes      = (i == len - 1) ? 4'($urandom_range(1, 8)) : 4'd8;
      if (noisy && $urandom_range(0, 9) == 0) begin
        it.start_of_message = 1'($urandom_range(0, 1));
        it.valid_bytes      = 4'($urandom_range(0, 15));
      end
      send_word(it);
    end
  endtask

  initial begin
    int  len;
    int  r;
    int  phase_end;
    bit  first_msg;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset key and nonce
    send_fields(64'h0, 4'd8, 1'b1);
    send_fields('1, 4'd8, 1'b0);
    quiesce();

    write_reg(CFG_KEY01, '1);
    write_reg(CFG_KEY23, '1);
    write_reg(CFG_KEY45, '1);
    write_reg(CFG_KEY67, '1);
    write_reg(CFG_NONCE01, '1);
    write_reg(CFG_NONCE2, 64'h0000_0000_ffff_ffff);
    send_fields(64'h0, 4'd8, 1'b1);
    send_fields('1, 4'd4, 1'b0);
    send_fields({$urandom, $urandom}, 4'd8, 1'b1);
    quiesce();

    write_reg(CFG_KEY01, 64'h0706050403020100);
    write_reg(CFG_KEY23, 64'h0f0e0d0c0b0a0908);
    write_reg(CFG_KEY45, 64'h1716151413121110);
    write_reg(CFG_KEY67, 64'h1f1e1d1c1b1a1918);
    write_reg(CFG_NONCE01, 64'h4a000000_09000000);
    write_reg(CFG_NONCE2, 64'h0);
    send_fields(64'h0, 4'd8, 1'b1);
    send_fields('1, 4'd1, 1'b0);
    send_fields('1, 4'd2, 1'b0);
    send_fields('1, 4'd3, 1'b0);
    send_fields('1, 4'd5, 1'b0);
    send_fields('1, 4'd7, 1'b0);
    send_fields('1, 4'd0, 1'b0);
    send_fields('1, 4'd9, 1'b0);
    // ninth word runs into the second block
    send_fields('1, 4'd15, 1'b0);
    send_fields({$urandom, $urandom}, 4'd8, 1'b0);
    // restart part way through a block
    send_fields({$urandom, $urandom}, 4'd8, 1'b1);
    send_fields({$urandom, $urandom}, 4'd8, 1'b0);
    quiesce();

    // nonce change mid-message: rest of this block keeps the old nonce
    write_reg(CFG_NONCE2, 64'h0000_0000_a5c3_0f96);
    repeat (8) send_fields({$urandom, $urandom}, 4'd8, 1'b0);
    quiesce();

    while (words_sent < WORD_TARGET) begin
      for (int i = 0; i < 6; i++)
        if ($urandom_range(0, 3) != 0)
          write_reg(3'(i), pick_reg_value(i == int'(CFG_NONCE2)));
      idle_on   = ($urandom_range(0, 3) != 0);
      phase_end = words_sent + $urandom_range(50, 100);
      if (phase_end > WORD_TARGET) phase_end = WORD_TARGET;
      first_msg = 1'b1;
      while (words_sent < phase_end) begin
        r = $urandom_range(0, 99);
        if (r < 70)      len = $urandom_range(1, 16);
        else if (r < 95) len = $urandom_range(17, 40);
        else             len = $urandom_range(41, 80);
        send_message(len, !(first_msg && $urandom_range(0, 2) == 0),
                     $urandom_range(0, 5) == 0);
        first_msg = 1'b0;
        if ($urandom_range(0, 9) == 0) wait_drained();
      end
      quiesce();
    end

    if (ks_board.errors == 0 && ks_board.expected_words.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
sv/cc20_pkg.sv
sv/cc20_front.sv
sv/cc20_core.sv
sv/cc20_back.sv
sv/chacha20_stream_cipher.sv
tb/chacha20_stream_cipher_test.sv
